[hdl/fts_pkg.sv]
// Shared constants for the face track smoother.
// No dependencies; the channel interfaces and the top level import it.
package fts_pkg;

  localparam int AvgDepth = 4;
  localparam int IdxW     = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;

  localparam int CoordW  = 13;
  localparam int SizeW   = 12;
  localparam int PixW    = 12;
  localparam int RadW    = 13;
  localparam int HoldW   = 4;
  localparam int SampleW = 13;
  localparam int SumW    = SampleW + $clog2(AvgDepth);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxHolds    = 2'd2;

  localparam logic [PixW-1:0]    FrameWidthRst  = 12'd640;
  localparam logic [PixW-1:0]    FrameHeightRst = 12'd480;
  localparam logic [HoldW-1:0]   MaxHoldsRst    = 4'd3;
  localparam logic [SampleW-1:0] RingRst        = 13'd120;
  localparam logic [RadW-1:0]    RadiusMin      = 13'd4;

endpackage

[hdl/fts_in_if.sv]
// Input channel: one detected face rectangle per item.
// Depends on fts_pkg for field widths.
interface fts_in_if import fts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] rect_x;
  logic signed [CoordW-1:0] rect_y;
  logic [SizeW-1:0]         rect_width;
  logic [SizeW-1:0]         rect_height;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

[hdl/fts_out_if.sv]
// Output channel: smoothed face centre, radius and hold flag per item.
// Depends on fts_pkg for field widths.
interface fts_out_if import fts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] center_x;
  logic [PixW-1:0] center_y;
  logic [RadW-1:0] radius_quarters;
  logic            held;

  modport source (output valid, center_x, center_y, radius_quarters, held, input ready);
  modport sink   (input valid, center_x, center_y, radius_quarters, held, output ready);
endinterface

[hdl/face_track_smoother.sv]
// Face track smoother: ring-averaged radius, clamped centre, glitch hold.
// Depends on fts_pkg, fts_in_if and fts_out_if.
// Results pass through the input stage registers, then the result stage registers.
// Throughput: one item per cycle while the output is not stalled; the hold decision
// and the previous location update close together in the result stage.
// Reset: async active low; ring to 120 each, config to 640/480/3, first frame set.
module face_track_smoother import fts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fts_in_if.sink              in_i,
  fts_out_if.source           out_o
);

  logic [PixW-1:0]    fw_q, fh_q;
  logic [HoldW-1:0]   maxh_q;

  logic [SampleW-1:0] ring_q [AvgDepth];
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [SumW-1:0]    sum_q, sum_d;

  logic               s1_v_q;
  logic [PixW-1:0]    s1_cx_q, s1_cy_q;
  logic [RadW-1:0]    s1_r_q;

  logic               out_v_q, held_q, first_q;
  logic [PixW-1:0]    cx_q, cy_q;
  logic [RadW-1:0]    r_q;
  logic [HoldW-1:0]   hold_q;

  logic               s1_adv, in_acc;

  logic [SampleW-1:0]      sample;
  logic [RadW-1:0]         avg, r_lo, r_c, rmax;
  logic signed [CoordW:0]  ctr_x, ctr_y;
  logic [PixW-1:0]         cx_c, cy_c;

  logic [PixW-1:0]    adx, ady;
  logic [2*PixW:0]    d2;
  logic [2*RadW-1:0]  r2;
  logic [RadW-1:0]    diff;
  logic [RadW+1:0]    diff3;
  logic               jump, grow, held_d;

  function automatic logic [PixW-1:0] clamp_c(logic signed [CoordW:0] c, logic [PixW-1:0] hi);
    logic [PixW-1:0] res;
    if (c[CoordW]) begin
      res = '0;
    end else if (c[CoordW-1:0] > {1'b0, hi}) begin
      res = hi;
    end else begin
      res = c[PixW-1:0];
    end
    return res;
  endfunction

  assign s1_adv     = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FrameWidthRst;
      fh_q   <= FrameHeightRst;
      maxh_q <= MaxHoldsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFrameWidth:  fw_q   <= cfg_data_i[PixW-1:0];
        CfgFrameHeight: fh_q   <= cfg_data_i[PixW-1:0];
        CfgMaxHolds:    maxh_q <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // input stage: ring, running sum, centre and radius clamps
  always_comb begin
    sample = {1'b0, in_i.rect_width} + {1'b0, in_i.rect_height};
    sum_d  = sum_q - SumW'(ring_q[idx_q]) + SumW'(sample);
    idx_d  = (idx_q == IdxW'(AvgDepth - 1)) ? '0 : IdxW'(idx_q + 1'b1);
    avg    = RadW'(sum_d / SumW'(AvgDepth));
    rmax   = {fw_q[PixW-1:1], 2'b00};
    r_lo   = (avg < RadiusMin) ? RadiusMin : avg;
    r_c    = (r_lo > rmax) ? rmax : r_lo;
    ctr_x  = {in_i.rect_x[CoordW-1], in_i.rect_x}
           + $signed({3'b000, in_i.rect_width[SizeW-1:1]});
    ctr_y  = {in_i.rect_y[CoordW-1], in_i.rect_y}
           + $signed({3'b000, in_i.rect_height[SizeW-1:1]});
    cx_c   = clamp_c(ctr_x, fw_q);
    cy_c   = clamp_c(ctr_y, fh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AvgDepth; i++) begin
        ring_q[i] <= RingRst;
      end
      idx_q  <= '0;
      sum_q  <= SumW'(RingRst) * SumW'(AvgDepth);
      s1_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ring_q[idx_q] <= sample;
        idx_q         <= idx_d;
        sum_q         <= sum_d;
      end
      if (in_i.ready) begin
        s1_v_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cx_q <= cx_c;
      s1_cy_q <= cy_c;
      s1_r_q  <= r_c;
    end
  end

  // result stage: glitch tests against previous location
  always_comb begin
    adx    = (s1_cx_q >= cx_q) ? s1_cx_q - cx_q : cx_q - s1_cx_q;
    ady    = (s1_cy_q >= cy_q) ? s1_cy_q - cy_q : cy_q - s1_cy_q;
    d2     = (2*PixW+1)'(adx * adx) + (2*PixW+1)'(ady * ady);
    r2     = s1_r_q * s1_r_q;
    jump   = {d2, 2'b00} > {1'b0, r2};
    diff   = (s1_r_q >= r_q) ? s1_r_q - r_q : r_q - s1_r_q;
    diff3  = {2'b00, diff} + {1'b0, diff, 1'b0};
    grow   = diff3 > {1'b0, r_q, 1'b0};
    held_d = !first_q && (hold_q < maxh_q) && (jump || grow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      held_q  <= 1'b0;
      first_q <= 1'b1;
      hold_q  <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      r_q     <= '0;
    end else if (s1_adv) begin
      out_v_q <= s1_v_q;
      if (s1_v_q) begin
        first_q <= 1'b0;
        held_q  <= held_d;
        if (held_d) begin
          hold_q <= HoldW'(hold_q + 1'b1);
        end else begin
          hold_q <= '0;
          cx_q   <= s1_cx_q;
          cy_q   <= s1_cy_q;
          r_q    <= s1_r_q;
        end
      end
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.center_x        = cx_q;
  assign out_o.center_y        = cy_q;
  assign out_o.radius_quarters = r_q;
  assign out_o.held            = held_q;

`ifndef ASSERT_OFF
  a_hold_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_adv && held_d) |=> ($stable(cx_q) && $stable(cy_q) && $stable(r_q)))
    else $error("held item changed the previous location");

  a_first_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_adv && first_q) |=> !held_q)
    else $error("first item was held");

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_adv && held_d) |=> (hold_q == HoldW'($past(hold_q) + 1'b1)))
    else $error("hold count did not advance on a held item");
`endif

endmodule

[bench/tb_top.sv]
// Testbench for face_track_smoother: directed table, then smoothly moving faces
// with jumps and noise, checked against an in-bench tracker model or typed table values.
// Depends on fts_pkg, fts_in_if, fts_out_if and the face_track_smoother RTL.
`timescale 1ns / 100ps

module tb_top;
  import fts_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
  } rect_t;

  typedef struct packed {
    logic [PixW-1:0] cx;
    logic [PixW-1:0] cy;
    logic [RadW-1:0] rq;
    logic            held;
  } track_t;

  typedef struct {
    bit     reg_wr;
    int     fw;
    int     fh;
    int     mh;
    rect_t  f;
    bit     typed;
    track_t want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fts_in_if  in_if ();
  fts_out_if out_if ();

  face_track_smoother DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int frame_w, frame_h, hold_cap;
  logic [SampleW-1:0] ring [AvgDepth];
  int ring_pos;
  int last_cx, last_cy, last_rq;
  bit fresh;
  int hold_run;

  track_t    due_tracks [$];
  plan_row_t plan [$];

  int  mismatches, results_seen, held_seen, frames_sent, reg_writes;
  bit  calm, squeeze_req;
  int  face_cx, face_cy, face_sz;

  localparam int SqueezeCycles = 80;

  function automatic track_t smooth_frame(input rect_t f);
    track_t o;
    int sum, rad, rmax, cx, cy;
    longint dx, dy, diff;
    bit glitch;
    ring[ring_pos] = SampleW'(f.w) + SampleW'(f.h);
    ring_pos = (ring_pos == AvgDepth - 1) ? 0 : ring_pos + 1;
    sum = 0;
    for (int i = 0; i < AvgDepth; i++) sum += int'(ring[i]);
    rad = sum / AvgDepth;
    cx = int'($signed(f.x)) + int'(f.w >> 1);
    cy = int'($signed(f.y)) + int'(f.h >> 1);
    cx = (cx < 0) ? 0 : (cx > frame_w) ? frame_w : cx;
    cy = (cy < 0) ? 0 : (cy > frame_h) ? frame_h : cy;
    if (rad < int'(RadiusMin)) rad = int'(RadiusMin);
    rmax = (frame_w / 2) * 4;
    if (rad > rmax) rad = rmax;
    glitch = 1'b0;
    if (!fresh && hold_run < hold_cap) begin
      dx = cx - last_cx;
      dy = cy - last_cy;
      diff = (rad > last_rq) ? rad - last_rq : last_rq - rad;
      glitch = (4 * (dx * dx + dy * dy) > longint'(rad) * rad) ||
               (3 * diff > 2 * longint'(last_rq));
    end
    if (glitch) begin
      cx = last_cx;
      cy = last_cy;
      rad = last_rq;
      hold_run++;
    end else begin
      hold_run = 0;
    end
    last_cx = cx;
    last_cy = cy;
    last_rq = rad;
    fresh = 1'b0;
    o.cx = PixW'(cx);
    o.cy = PixW'(cy);
    o.rq = RadW'(rad);
    o.held = glitch;
    return o;
  endfunction

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic rect_t next_face();
    rect_t f;
    int pick, w, h;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      f.x = CoordW'($urandom);
      f.y = CoordW'($urandom);
      f.w = SizeW'($urandom);
      f.h = SizeW'($urandom);
      return f;
    end
    if (pick < 22) begin
      face_cx = $urandom_range(0, frame_w);
      face_cy = $urandom_range(0, frame_h);
      face_sz = $urandom_range(8, 400);
    end else begin
      face_cx += int'($urandom_range(0, 6)) - 3;
      face_cy += int'($urandom_range(0, 6)) - 3;
      face_sz += int'($urandom_range(0, 4)) - 2;
      if (face_sz < 8) face_sz = 8;
      if (face_sz > 400) face_sz = 400;
    end
    w = face_sz + int'($urandom_range(0, 4)) - 2;
    h = face_sz + int'($urandom_range(0, 4)) - 2;
    f.w = SizeW'(w);
    f.h = SizeW'(h);
    f.x = CoordW'(face_cx - w / 2);
    f.y = CoordW'(face_cy - h / 2);
    return f;
  endfunction

  function automatic plan_row_t frame_row(input int x, input int y, input int w, input int h);
    plan_row_t r;
    r.reg_wr = 1'b0;
    r.fw = 0;
    r.fh = 0;
    r.mh = 0;
    r.f.x = CoordW'(x);
    r.f.y = CoordW'(y);
    r.f.w = SizeW'(w);
    r.f.h = SizeW'(h);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input int x, input int y, input int w, input int h,
                                          input int cx, input int cy, input int rq,
                                          input bit hd);
    plan_row_t r;
    r = frame_row(x, y, w, h);
    r.typed = 1'b1;
    r.want.cx = PixW'(cx);
    r.want.cy = PixW'(cy);
    r.want.rq = RadW'(rq);
    r.want.held = hd;
    return r;
  endfunction

  function automatic plan_row_t setup_row(input int fw, input int fh, input int mh);
    plan_row_t r;
    r = frame_row(0, 0, 0, 0);
    r.reg_wr = 1'b1;
    r.fw = fw;
    r.fh = fh;
    r.mh = mh;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("Mismatch at result %0d: %s got %0d, want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_frame(input int fw, input int fh, input int mh);
    in_if.valid <= 1'b0;
    while (due_tracks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CfgFrameWidth, fw);
    write_reg(CfgFrameHeight, fh);
    write_reg(CfgMaxHolds, mh);
    frame_w = fw & 'hFFF;
    frame_h = fh & 'hFFF;
    hold_cap = mh & 'hF;
  endtask

  task automatic push_rect(input rect_t f, input bit typed, input track_t want);
    int gap;
    track_t model;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.rect_x      <= f.x;
    in_if.rect_y      <= f.y;
    in_if.rect_width  <= f.w;
    in_if.rect_height <= f.h;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    model = smooth_frame(f);
    due_tracks.push_back(typed ? want : model);
    frames_sent++;
  endtask

  initial begin : sink_ready
    int stall_left;
    int g;
    stall_left = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left = SqueezeCycles;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        g = idle_gap();
        if (g > 0) begin
          out_if.ready <= 1'b0;
          stall_left = g - 1;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    track_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.held) held_seen++;
      if (due_tracks.size() == 0) begin
        flag_mismatch("result with none pending, center_x", out_if.center_x, 0);
      end else begin
        want = due_tracks.pop_front();
        if (out_if.center_x !== want.cx)
          flag_mismatch("center_x", out_if.center_x, want.cx);
        if (out_if.center_y !== want.cy)
          flag_mismatch("center_y", out_if.center_y, want.cy);
        if (out_if.radius_quarters !== want.rq)
          flag_mismatch("radius_quarters", out_if.radius_quarters, want.rq);
        if (out_if.held !== want.held)
          flag_mismatch("held", out_if.held, want.held);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase, k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.rect_x = '0;
    in_if.rect_y = '0;
    in_if.rect_width = '0;
    in_if.rect_height = '0;
    calm = 1'b0;
    squeeze_req = 1'b0;

    for (int i = 0; i < AvgDepth; i++) ring[i] = RingRst;
    ring_pos = 0;
    last_cx = 0;
    last_cy = 0;
    last_rq = 0;
    fresh = 1'b1;
    hold_run = 0;
    frame_w = int'(FrameWidthRst);
    frame_h = int'(FrameHeightRst);
    hold_cap = int'(MaxHoldsRst);

    // reset settings: first frame, jumps held up to the hold limit, then released
    plan.push_back(typed_row(100, 50, 60, 40, 130, 70, 115, 1'b0));
    plan.push_back(typed_row(-4096, -4096, 0, 0, 130, 70, 115, 1'b1));
    plan.push_back(typed_row(4095, 4095, 4095, 4095, 130, 70, 115, 1'b1));
    plan.push_back(frame_row(600, 460, 80, 40));
    plan.push_back(frame_row(600, 460, 80, 40));
    plan.push_back(frame_row(0, 0, 4095, 0));
    plan.push_back(frame_row(-1, -1, 1, 1));
    plan.push_back(frame_row(260, 160, 80, 80));
    plan.push_back(frame_row(262, 161, 80, 82));
    plan.push_back(frame_row(263, 163, 78, 80));
    // one-pixel frame width forces radius zero; no holds allowed
    plan.push_back(setup_row(1, 4095, 0));
    plan.push_back(typed_row(0, 10, 2, 4, 1, 12, 0, 1'b0));
    plan.push_back(typed_row(4095, 4095, 4095, 4095, 1, 4095, 0, 1'b0));
    plan.push_back(typed_row(-4096, 100, 0, 0, 0, 100, 0, 1'b0));
    // widest frame, one-line height, longest hold run
    plan.push_back(setup_row(4095, 1, 15));
    plan.push_back(frame_row(2000, 0, 100, 100));
    plan.push_back(frame_row(10, 0, 100, 100));
    plan.push_back(frame_row(3900, 0, 100, 100));
    plan.push_back(frame_row(10, 0, 100, 100));
    plan.push_back(frame_row(2000, 0, 2047, 2047));
    plan.push_back(setup_row(640, 480, 3));
    plan.push_back(frame_row(300, 200, 60, 60));
    plan.push_back(frame_row(301, 200, 60, 60));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].reg_wr) set_frame(plan[i].fw, plan[i].fh, plan[i].mh);
      else push_rect(plan[i].f, plan[i].typed, plan[i].want);
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_frame(4095, 4095, 15);
        1: set_frame(1, 1, 0);
        2: set_frame(640, 480, 3);
        3: set_frame(4095, 1, 0);
        default: set_frame($urandom_range(1, 4095), $urandom_range(1, 4095),
                           $urandom_range(0, 15));
      endcase
      calm = (phase % 3 == 1);
      face_cx = frame_w / 2;
      face_cy = frame_h / 2;
      face_sz = 8 + $urandom_range(0, 120);
      for (k = 0; k < 85; k++) begin
        if (phase == 2 && k == 20) squeeze_req = 1'b1;
        push_rect(next_face(), 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (due_tracks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d frames and %0d results, %0d of them held, over %0d register writes",
             frames_sent, results_seen, held_seen, reg_writes);
    $display("Frame size and hold limit swept to both ends; output stalled once for %0d cycles",
             SqueezeCycles);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
